>>> design/ase_pkg.sv
package ase_pkg;

	localparam int DMEM_BYTES = 4096;
	localparam int DMEM_ROWS  = (DMEM_BYTES + 7) / 8;
	localparam int ROW_W      = $clog2(DMEM_ROWS);

	localparam logic [4:0] OP_UNK   = 5'd0;
	localparam logic [4:0] OP_BCOND = 5'd1;
	localparam logic [4:0] OP_B     = 5'd2;
	localparam logic [4:0] OP_CBZ   = 5'd3;
	localparam logic [4:0] OP_CBNZ  = 5'd4;
	localparam logic [4:0] OP_BR    = 5'd5;
	localparam logic [4:0] OP_HLT   = 5'd6;
	localparam logic [4:0] OP_ADD   = 5'd7;
	localparam logic [4:0] OP_ADDS  = 5'd8;
	localparam logic [4:0] OP_SUBS  = 5'd9;
	localparam logic [4:0] OP_ANDS  = 5'd10;
	localparam logic [4:0] OP_EOR   = 5'd11;
	localparam logic [4:0] OP_ORR   = 5'd12;
	localparam logic [4:0] OP_ADDI  = 5'd13;
	localparam logic [4:0] OP_ADDSI = 5'd14;
	localparam logic [4:0] OP_SUBSI = 5'd15;
	localparam logic [4:0] OP_ADCS  = 5'd16;
	localparam logic [4:0] OP_MUL   = 5'd17;
	localparam logic [4:0] OP_MOVZ  = 5'd18;
	localparam logic [4:0] OP_LSL   = 5'd19;
	localparam logic [4:0] OP_LSR   = 5'd20;
	localparam logic [4:0] OP_LD    = 5'd21;
	localparam logic [4:0] OP_ST    = 5'd22;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_UNK   = 3'd2;
	localparam logic [2:0] ST_FAULT = 3'd3;
	localparam logic [2:0] ST_COND  = 3'd4;

	localparam logic REG_START_PC  = 1'b0;
	localparam logic REG_DATA_BASE = 1'b1;

	localparam logic [63:0] RESET_PC   = 64'h0000_0000_0040_0000;
	localparam logic [63:0] RESET_BASE = 64'h0000_0000_1000_0000;

	typedef struct packed {
		logic [4:0]  op;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [4:0]  rm;
		logic [5:0]  sh;
		logic [63:0] imm;
		logic [2:0]  nbm1;
		logic [3:0]  cond;
	} dec_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic [2:0]  status;
		logic        dest_written;
		logic [4:0]  dest_index;
		logic [63:0] dest_value;
		logic [3:0]  nzcv;
	} res_t;

	typedef struct packed {
		logic        we;
		logic        index;
		logic [63:0] data;
	} cfg_t;

endpackage

>>> design/arm64_subset_execute.sv
// Executes one 32-bit A64 instruction per transaction and returns one result per
// instruction, in order. A decode stage classifies each word into a two-entry queue;
// the execute unit then reads the register file when it issues the instruction and
// computes and writes back in its execute state once the result queue has room. MUL
// first forms split 32-bit partial products; loads/stores first add the address,
// then do a byte-lane memory read or write. After reset the data memory is cleared
// one 8-byte row per cycle, (DMEM_BYTES+7)/8 rows (512 by default); full stays high.
module arm64_subset_execute import ase_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] instruction,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] next_pc,
	output logic [2:0]  status,
	output logic        dest_written,
	output logic [4:0]  dest_index,
	output logic [63:0] dest_value,
	output logic [3:0]  nzcv,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	dec_t head;
	logic head_vld, head_pop, fq_full, clr_busy, res_push, res_full;
	res_t res, res_out;
	cfg_t cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;
	assign full      = fq_full || clr_busy;

	ase_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push && !clr_busy), .instruction(instruction),
		.full(fq_full), .head(head), .head_vld(head_vld), .head_pop(head_pop)
	);

	ase_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .head(head), .head_vld(head_vld),
		.head_pop(head_pop), .clr_busy(clr_busy), .res(res), .res_push(res_push),
		.res_full(res_full)
	);

	ase_resq u_resq (
		.clk(clk), .arst_n(arst_n), .din(res), .wr(res_push), .full(res_full),
		.dout(res_out), .empty(empty), .rd(pop)
	);

	assign next_pc      = res_out.next_pc;
	assign status       = res_out.status;
	assign dest_written = res_out.dest_written;
	assign dest_index   = res_out.dest_index;
	assign dest_value   = res_out.dest_value;
	assign nzcv         = res_out.nzcv;

endmodule

>>> design/ase_front.sv
module ase_front import ase_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [31:0] instruction,
	output logic        full,
	output dec_t        head,
	output logic        head_vld,
	input  logic        head_pop
);

	dec_t       d;
	dec_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic [10:0] op11;
	logic [5:0]  imms;
	logic [5:0]  immr;

	assign op11 = instruction[31:21];
	assign imms = instruction[15:10];
	assign immr = instruction[21:16];

	// classification follows the encoding priority of the subset
	always_comb begin
		d      = '0;
		d.op   = OP_UNK;
		d.rd   = instruction[4:0];
		d.rn   = instruction[9:5];
		d.rm   = instruction[20:16];
		d.sh   = instruction[15:10];
		d.cond = instruction[3:0];
		if (instruction[31:24] == 8'h54 && !instruction[4]) begin
			d.op  = OP_BCOND;
			d.imm = {{43{instruction[23]}}, instruction[23:5], 2'b00};
		end else if (instruction[31:26] == 6'h05) begin
			d.op  = OP_B;
			d.imm = {{36{instruction[25]}}, instruction[25:0], 2'b00};
		end else if (instruction[31:24] == 8'hB4 || instruction[31:24] == 8'hB5) begin
			d.op  = instruction[24] ? OP_CBNZ : OP_CBZ;
			d.imm = {{43{instruction[23]}}, instruction[23:5], 2'b00};
		end else if ((instruction & 32'hFFFF_FC1F) == 32'hD61F_0000) begin
			d.op = OP_BR;
		end else if (op11 == 11'h6A2 && instruction[4:0] == 5'd0) begin
			d.op = OP_HLT;
		end else if (op11 == 11'h458) begin
			d.op = OP_ADD;
		end else if (op11 == 11'h558) begin
			d.op = OP_ADDS;
		end else if (op11 == 11'h758) begin
			d.op = OP_SUBS;
		end else if (op11 == 11'h750) begin
			d.op = OP_ANDS;
		end else if (op11 == 11'h650) begin
			d.op = OP_EOR;
		end else if (op11 == 11'h550) begin
			d.op = OP_ORR;
		end else if (instruction[31:23] == 9'h122 || instruction[31:23] == 9'h162 ||
				instruction[31:23] == 9'h1E2) begin
			d.op  = (instruction[31:23] == 9'h122) ? OP_ADDI :
				(instruction[31:23] == 9'h162) ? OP_ADDSI : OP_SUBSI;
			d.imm = instruction[22] ? {40'd0, instruction[21:10], 12'd0} :
				{52'd0, instruction[21:10]};
		end else if (op11 == 11'h5D0 && imms == 6'd0) begin
			d.op = OP_ADCS;
		end else if (op11 == 11'h4D8 && imms == 6'h1F) begin
			d.op = OP_MUL;
		end else if (op11 == 11'h694) begin
			d.op  = OP_MOVZ;
			d.imm = {48'd0, instruction[20:5]};
		end else if (instruction[31:22] == 10'h34D &&
				(imms == 6'h3F || ({1'b0, imms} + 7'd1) == {1'b0, immr})) begin
			if (imms == 6'h3F) begin
				d.op = OP_LSR;
				d.sh = immr;
			end else begin
				d.op = OP_LSL;
				d.sh = ~imms;
			end
		end else if ((op11 == 11'h7C2 || op11 == 11'h1C2 || op11 == 11'h3C2 ||
				op11 == 11'h7C0 || op11 == 11'h1C0 || op11 == 11'h3C0) &&
				instruction[11:10] == 2'b00) begin
			d.op   = op11[1] ? OP_LD : OP_ST;
			d.nbm1 = (op11[10:9] == 2'd3) ? 3'd7 : ((op11[10:9] == 2'd1) ? 3'd1 : 3'd0);
			d.imm  = {{55{instruction[20]}}, instruction[20:12]};
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign head_vld = (cnt_q != 2'd0);
	assign head     = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (head_pop && head_vld) begin
				rp_q <= ~rp_q;
			end
			case ({push && !full, head_pop && head_vld})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/ase_back.sv
module ase_back import ase_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  dec_t head,
	input  logic head_vld,
	output logic head_pop,
	output logic clr_busy,
	output res_t res,
	output logic res_push,
	input  logic res_full
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_AG   = 3'd2;
	localparam logic [2:0] S_MEM  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_EX   = 3'd5;

	localparam logic [3:0] CC_EQ = 4'h0;
	localparam logic [3:0] CC_NE = 4'h1;
	localparam logic [3:0] CC_GE = 4'hA;
	localparam logic [3:0] CC_LT = 4'hB;
	localparam logic [3:0] CC_GT = 4'hC;
	localparam logic [3:0] CC_LE = 4'hD;

	logic [2:0]       state_q;
	logic [ROW_W-1:0] clr_cnt_q;
	dec_t             cur_q;
	logic [63:0]      pc_q;
	logic [63:0]      base_q;
	logic [3:0]       flags_q;
	logic             halted_q;

	// two copies of the register file give three read ports
	logic [63:0] rfa [32];
	logic [63:0] rfb [32];
	logic [31:0] rf_vld_q;
	logic [63:0] rn_q, rm_q, rd_q;
	logic        rn_vld_q, rm_vld_q, rd_vld_q;
	logic [63:0] xn, xm, xd;

	logic [63:0] off_q;
	logic        fault;
	logic        fault_q;
	logic [63:0] p0_q;
	logic [31:0] p1_q, p2_q;

	logic [7:0]       brd_q [8];
	logic [7:0]       bwe;
	logic [ROW_W-1:0] brow [8];
	logic [7:0]       bwdata [8];
	logic             issue;
	logic             commit;

	assign xn = rn_vld_q ? rn_q : 64'd0;
	assign xm = rm_vld_q ? rm_q : 64'd0;
	assign xd = rd_vld_q ? rd_q : 64'd0;

	assign clr_busy = (state_q == S_CLR);
	assign issue    = (state_q == S_IDLE) && head_vld;
	assign head_pop = issue;
	assign fault    = off_q > (64'(DMEM_BYTES - 1) - 64'(cur_q.nbm1));

	// byte lanes: lane b holds byte i of the access when i <= nbm1
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			logic [2:0] i;
			i = 3'(b) - off_q[2:0];
			brow[b]   = off_q[ROW_W+2:3] + ROW_W'(3'(b) < off_q[2:0]);
			bwdata[b] = 8'(xd >> {i, 3'b000});
			bwe[b]    = (state_q == S_MEM) && (cur_q.op == OP_ST) && !fault &&
				(i <= cur_q.nbm1);
			if (state_q == S_CLR) begin
				brow[b]   = clr_cnt_q;
				bwdata[b] = 8'd0;
				bwe[b]    = 1'b1;
			end
		end
	end

	for (genvar g = 0; g < 8; g++) begin : g_lane
		logic [7:0] mem [DMEM_ROWS];
		always_ff @(posedge clk) begin
			if (bwe[g]) begin
				mem[brow[g]] <= bwdata[g];
			end
			if (state_q == S_MEM) begin
				brd_q[g] <= mem[brow[g]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q    <= head;
			rn_q     <= rfa[head.rn];
			rm_q     <= rfa[head.rm];
			rd_q     <= rfb[head.rd];
		end
		if (state_q == S_AG) begin
			off_q <= xn + cur_q.imm - base_q;
		end
		if (state_q == S_MEM) begin
			fault_q <= fault;
		end
		if (state_q == S_MUL) begin
			p0_q <= xn[31:0] * xm[31:0];
			p1_q <= 32'(xn[31:0] * xm[63:32]);
			p2_q <= 32'(xn[63:32] * xm[31:0]);
		end
		if (commit && res.dest_written) begin
			rfa[cur_q.rd] <= res.dest_value;
			rfb[cur_q.rd] <= res.dest_value;
		end
	end

	// execute
	logic [63:0] sb, bb, sum_r, tgt, ld, val;
	logic [64:0] sum;
	logic        cin, wr, take, known, halt_set;
	logic [3:0]  aflags, flags_n;
	logic [2:0]  status;
	logic [63:0] npc;

	always_comb begin
		sb  = xm << cur_q.sh;
		bb  = sb;
		cin = 1'b0;
		case (cur_q.op)
			OP_SUBS:  begin bb = ~sb; cin = 1'b1; end
			OP_ADDI, OP_ADDSI: bb = cur_q.imm;
			OP_SUBSI: begin bb = ~cur_q.imm; cin = 1'b1; end
			OP_ADCS:  begin bb = xm; cin = flags_q[1]; end
			default:  bb = sb;
		endcase
		sum    = {1'b0, xn} + {1'b0, bb} + 65'(cin);
		sum_r  = sum[63:0];
		aflags = {sum_r[63], sum_r == 64'd0, sum[64], ((xn ^ sum_r) & (bb ^ sum_r)) >> 63 != 64'd0};
		tgt    = pc_q + cur_q.imm;
		ld     = '0;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) <= cur_q.nbm1) begin
				ld[8*i +: 8] = brd_q[3'(i) + off_q[2:0]];
			end
		end
		known = 1'b1;
		case (cur_q.cond)
			CC_EQ: take = flags_q[2];
			CC_NE: take = !flags_q[2];
			CC_GE: take = flags_q[3] == flags_q[0];
			CC_LT: take = flags_q[3] != flags_q[0];
			CC_GT: take = !flags_q[2] && flags_q[3] == flags_q[0];
			CC_LE: take = flags_q[2] || flags_q[3] != flags_q[0];
			default: begin take = 1'b0; known = 1'b0; end
		endcase
		npc      = pc_q + 64'd4;
		status   = ST_OK;
		wr       = 1'b0;
		val      = '0;
		flags_n  = flags_q;
		halt_set = 1'b0;
		if (halted_q) begin
			npc    = pc_q;
			status = ST_HALT;
		end else begin
			case (cur_q.op)
				OP_BCOND: begin
					if (!known) status = ST_COND;
					else if (take) npc = tgt;
				end
				OP_B:    npc = tgt;
				OP_CBZ:  if (xd == 64'd0) npc = tgt;
				OP_CBNZ: if (xd != 64'd0) npc = tgt;
				OP_BR:   npc = xn;
				OP_HLT:  begin halt_set = 1'b1; status = ST_HALT; end
				OP_ADD, OP_ADDI: begin val = sum_r; wr = 1'b1; end
				OP_ADDS, OP_SUBS, OP_ADDSI, OP_SUBSI, OP_ADCS: begin
					val = sum_r; wr = 1'b1; flags_n = aflags;
				end
				OP_ANDS: begin
					val = xn & sb; wr = 1'b1;
					flags_n = {val[63], val == 64'd0, 2'b00};
				end
				OP_EOR:  begin val = xn ^ sb; wr = 1'b1; end
				OP_ORR:  begin val = xn | sb; wr = 1'b1; end
				OP_MUL:  begin val = p0_q + {p1_q + p2_q, 32'd0}; wr = 1'b1; end
				OP_MOVZ: begin val = cur_q.imm; wr = 1'b1; end
				OP_LSL:  begin val = xn << cur_q.sh; wr = 1'b1; end
				OP_LSR:  begin val = xn >> cur_q.sh; wr = 1'b1; end
				OP_LD: begin
					if (fault_q) status = ST_FAULT;
					else begin val = ld; wr = 1'b1; end
				end
				OP_ST:   if (fault_q) status = ST_FAULT;
				default: status = ST_UNK;
			endcase
		end
		if (cur_q.rd == 5'd31) begin
			wr = 1'b0;
		end
		res.next_pc      = npc;
		res.status       = status;
		res.dest_written = wr;
		res.dest_index   = wr ? cur_q.rd : 5'd0;
		res.dest_value   = wr ? val : 64'd0;
		res.nzcv         = flags_n;
	end

	assign commit   = (state_q == S_EX) && !res_full;
	assign res_push = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_cnt_q <= '0;
			pc_q      <= RESET_PC;
			base_q    <= RESET_BASE;
			flags_q   <= 4'd0;
			halted_q  <= 1'b0;
			rf_vld_q  <= '0;
			rn_vld_q  <= 1'b0;
			rm_vld_q  <= 1'b0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cfg.we && cfg.index == REG_START_PC) begin
				pc_q <= cfg.data;
			end else if (commit) begin
				pc_q <= npc;
			end
			if (cfg.we && cfg.index == REG_DATA_BASE) begin
				base_q <= cfg.data;
			end
			if (issue) begin
				rn_vld_q <= rf_vld_q[head.rn];
				rm_vld_q <= rf_vld_q[head.rm];
				rd_vld_q <= rf_vld_q[head.rd];
			end
			if (commit) begin
				flags_q <= flags_n;
				if (halt_set) halted_q <= 1'b1;
				if (wr) rf_vld_q[cur_q.rd] <= 1'b1;
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + ROW_W'(1);
					if (clr_cnt_q == ROW_W'(DMEM_ROWS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (issue) begin
						if (halted_q) state_q <= S_EX;
						else if (head.op == OP_LD || head.op == OP_ST) state_q <= S_AG;
						else if (head.op == OP_MUL) state_q <= S_MUL;
						else state_q <= S_EX;
					end
				end
				S_AG:  state_q <= S_MEM;
				S_MEM: state_q <= S_EX;
				S_MUL: state_q <= S_EX;
				S_EX:  if (commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/ase_resq.sv
module ase_resq import ase_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  res_t din,
	input  logic wr,
	output logic full,
	output res_t dout,
	output logic empty,
	input  logic rd
);

	res_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr_ok;
	logic       rd_ok;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rp_q];
	assign wr_ok = wr && !full;
	assign rd_ok = rd && !empty;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_ok) wp_q <= ~wp_q;
			if (rd_ok) rp_q <= ~rp_q;
			case ({wr_ok, rd_ok})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> design/ase_check.sv
module ase_check import ase_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [63:0] next_pc,
	input logic [2:0]  status,
	input logic        dest_written,
	input logic [4:0]  dest_index,
	input logic [63:0] dest_value
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status <= ST_COND) else $error("status out of range");

	a_no_dest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !dest_written) |-> (dest_index == 5'd0 && dest_value == 64'd0))
		else $error("destination fields not cleared");

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> !dest_written)
		else $error("register written on a failing instruction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(next_pc)))
		else $error("result changed while waiting");

endmodule

bind arm64_subset_execute ase_check u_ase_check (.*);

>>> tb/sv/ase_tb_pkg.sv
`timescale 1ns / 1ps

package ase_tb_pkg;

	// 11-bit major opcodes, instruction bits 31..21
	localparam logic [10:0] OPC_ADD   = 11'h458;
	localparam logic [10:0] OPC_ADDS  = 11'h558;
	localparam logic [10:0] OPC_SUBS  = 11'h758;
	localparam logic [10:0] OPC_ANDS  = 11'h750;
	localparam logic [10:0] OPC_EOR   = 11'h650;
	localparam logic [10:0] OPC_ORR   = 11'h550;
	localparam logic [10:0] OPC_ADCS  = 11'h5D0;
	localparam logic [10:0] OPC_MUL   = 11'h4D8;
	localparam logic [10:0] OPC_MOVZ  = 11'h694;
	localparam logic [10:0] OPC_HLT   = 11'h6A2;
	localparam logic [10:0] OPC_STUR  = 11'h7C0;
	localparam logic [10:0] OPC_LDUR  = 11'h7C2;
	localparam logic [10:0] OPC_STURB = 11'h1C0;
	localparam logic [10:0] OPC_LDURB = 11'h1C2;
	localparam logic [10:0] OPC_STURH = 11'h3C0;
	localparam logic [10:0] OPC_LDURH = 11'h3C2;

	// immediate add/sub forms, bits 31..23
	localparam logic [8:0] IMM_ADD  = 9'h122;
	localparam logic [8:0] IMM_ADDS = 9'h162;
	localparam logic [8:0] IMM_SUBS = 9'h1E2;

	localparam logic [9:0]  UBFM_OP  = 10'h34D;
	localparam logic [7:0]  BCOND_OP = 8'h54;
	localparam logic [7:0]  CBZ_OP   = 8'hB4;
	localparam logic [7:0]  CBNZ_OP  = 8'hB5;
	localparam logic [5:0]  B_OP     = 6'h05;
	localparam logic [31:0] BR_WORD  = 32'hD61F_0000;
	localparam logic [31:0] BR_MASK  = 32'hFFFF_FC1F;
	localparam logic [5:0]  MUL_RA   = 6'h1F;

	localparam logic [3:0] COND_EQ = 4'h0;
	localparam logic [3:0] COND_NE = 4'h1;
	localparam logic [3:0] COND_GE = 4'hA;
	localparam logic [3:0] COND_LT = 4'hB;
	localparam logic [3:0] COND_GT = 4'hC;
	localparam logic [3:0] COND_LE = 4'hD;
	localparam logic [3:0] COND_AL = 4'hE;

endpackage

>>> tb/sv/ase_checker.sv
`timescale 1ns / 1ps

module ase_checker import ase_pkg::*; import ase_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [31:0] instruction,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] next_pc,
	input  logic [2:0]  status,
	input  logic        dest_written,
	input  logic [4:0]  dest_index,
	input  logic [63:0] dest_value,
	input  logic [3:0]  nzcv,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam int MEM_AW = $clog2(DMEM_BYTES);

	logic [63:0] gpr [32];
	logic [3:0]  flg;
	logic [63:0] pc;
	logic [63:0] base;
	logic        halted_q;
	logic [7:0]  mem [DMEM_BYTES];
	res_t        retire_q [$];

	function automatic logic [63:0] xreg(input logic [4:0] n);
		return (n == 5'd31) ? 64'd0 : gpr[n];
	endfunction

	function automatic logic [3:0] add_nzcv(input logic [63:0] a, input logic [63:0] b,
			input logic cin, output logic [63:0] r);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b} + {64'd0, cin};
		r = s[63:0];
		return {r[63], r == 64'd0, s[64], ((a ^ r) & (b ^ r)) >> 63 != 64'd0};
	endfunction

	function automatic logic [3:0] sub_nzcv(input logic [63:0] a, input logic [63:0] b,
			output logic [63:0] r);
		r = a - b;
		return {r[63], r == 64'd0, a >= b, ((a ^ b) & (a ^ r)) >> 63 != 64'd0};
	endfunction

	function automatic res_t execute(input logic [31:0] ins);
		logic [10:0] op11;
		logic [4:0]  rd, rn, rm;
		logic [5:0]  imm6, immr, imms;
		logic [63:0] npc, xn, xm, res, imm, off, src;
		logic        wr, take;
		logic [2:0]  st;
		int          sz;
		res_t        r;
		op11 = ins[31:21];
		rd   = ins[4:0];
		rn   = ins[9:5];
		rm   = ins[20:16];
		imm6 = ins[15:10];
		immr = ins[21:16];
		imms = ins[15:10];
		npc  = pc + 64'd4;
		xn   = xreg(rn);
		xm   = xreg(rm);
		res  = '0;
		wr   = 1'b0;
		take = 1'b0;
		st   = ST_OK;
		if (halted_q) begin
			st  = ST_HALT;
			npc = pc;
		end else if (ins[31:24] == BCOND_OP && !ins[4]) begin
			case (ins[3:0])
				COND_EQ: take = flg[2];
				COND_NE: take = !flg[2];
				COND_GE: take = flg[3] == flg[0];
				COND_LT: take = flg[3] != flg[0];
				COND_GT: take = !flg[2] && flg[3] == flg[0];
				COND_LE: take = flg[2] || flg[3] != flg[0];
				default: st = ST_COND;
			endcase
			if (take) npc = pc + ({{45{ins[23]}}, ins[23:5]} << 2);
		end else if (ins[31:26] == B_OP) begin
			npc = pc + ({{38{ins[25]}}, ins[25:0]} << 2);
		end else if (ins[31:24] == CBZ_OP || ins[31:24] == CBNZ_OP) begin
			take = (xreg(rd) == 64'd0) == (ins[31:24] == CBZ_OP);
			if (take) npc = pc + ({{45{ins[23]}}, ins[23:5]} << 2);
		end else if ((ins & BR_MASK) == BR_WORD) begin
			npc = xn;
		end else if (op11 == OPC_HLT && rd == 5'd0) begin
			halted_q = 1'b1;
			st       = ST_HALT;
		end else if (op11 == OPC_ADD) begin
			res = xn + (xm << imm6); wr = 1'b1;
		end else if (op11 == OPC_ADDS) begin
			flg = add_nzcv(xn, xm << imm6, 1'b0, res); wr = 1'b1;
		end else if (op11 == OPC_SUBS) begin
			flg = sub_nzcv(xn, xm << imm6, res); wr = 1'b1;
		end else if (op11 == OPC_ANDS) begin
			res = xn & (xm << imm6); flg = {res[63], res == 64'd0, 2'b00}; wr = 1'b1;
		end else if (op11 == OPC_EOR) begin
			res = xn ^ (xm << imm6); wr = 1'b1;
		end else if (op11 == OPC_ORR) begin
			res = xn | (xm << imm6); wr = 1'b1;
		end else if (ins[31:23] == IMM_ADD || ins[31:23] == IMM_ADDS || ins[31:23] == IMM_SUBS)
				begin
			imm = ins[22] ? {40'd0, ins[21:10], 12'd0} : {52'd0, ins[21:10]};
			if (ins[31:23] == IMM_ADD) res = xn + imm;
			else if (ins[31:23] == IMM_ADDS) flg = add_nzcv(xn, imm, 1'b0, res);
			else flg = sub_nzcv(xn, imm, res);
			wr = 1'b1;
		end else if (op11 == OPC_ADCS && imm6 == 6'd0) begin
			flg = add_nzcv(xn, xm, flg[1], res); wr = 1'b1;
		end else if (op11 == OPC_MUL && imm6 == MUL_RA) begin
			res = xn * xm; wr = 1'b1;
		end else if (op11 == OPC_MOVZ) begin
			res = {48'd0, ins[20:5]}; wr = 1'b1;
		end else if (ins[31:22] == UBFM_OP &&
				(imms == 6'd63 || {1'b0, imms} + 7'd1 == {1'b0, immr})) begin
			res = (imms == 6'd63) ? (xn >> immr) : (xn << (6'd63 - imms));
			wr  = 1'b1;
		end else if ((op11 == OPC_LDUR || op11 == OPC_LDURB || op11 == OPC_LDURH ||
				op11 == OPC_STUR || op11 == OPC_STURB || op11 == OPC_STURH) &&
				ins[11:10] == 2'b00) begin
			sz  = (op11[10:9] == 2'b11) ? 8 : ((op11[10:9] == 2'b01) ? 2 : 1);
			off = xn + {{55{ins[20]}}, ins[20:12]} - base;
			if (off > 64'(DMEM_BYTES - sz)) begin
				st = ST_FAULT;
			end else if (op11[1]) begin
				for (int i = 0; i < sz; i++)
					res |= 64'(mem[MEM_AW'(off + 64'(i))]) << (8 * i);
				wr = 1'b1;
			end else begin
				src = xreg(rd);
				for (int i = 0; i < sz; i++) mem[MEM_AW'(off + 64'(i))] = src[8 * i +: 8];
			end
		end else begin
			st = ST_UNK;
		end
		if (wr && rd != 5'd31) begin
			gpr[rd] = res;
		end else begin
			wr  = 1'b0;
			rd  = '0;
			res = '0;
		end
		pc = npc;
		r.next_pc      = npc;
		r.status       = st;
		r.dest_written = wr;
		r.dest_index   = rd;
		r.dest_value   = res;
		r.nzcv         = flg;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			foreach (gpr[i]) gpr[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			flg        = '0;
			pc         = RESET_PC;
			base       = RESET_BASE;
			halted_q   = 1'b0;
			retire_q.delete();
			fail_count = 0;
			pending   <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_START_PC) pc = cfg_data;
				else base = cfg_data;
			end
			if (pop && !empty) begin
				if (retire_q.size() == 0) begin
					$error("result transaction with no instruction outstanding");
					fail_count++;
				end else begin
					want = retire_q.pop_front();
					check_field("next_pc", want.next_pc, next_pc);
					check_field("status", 64'(want.status), 64'(status));
					check_field("dest_written", 64'(want.dest_written), 64'(dest_written));
					check_field("dest_index", 64'(want.dest_index), 64'(dest_index));
					check_field("dest_value", want.dest_value, dest_value);
					check_field("nzcv", 64'(want.nzcv), 64'(nzcv));
				end
			end
			if (push && !full) retire_q.push_back(execute(instruction));
			pending <= retire_q.size();
		end
	end

endmodule

>>> tb/sv/arm64_subset_execute_tb.sv
`timescale 1ns / 1ps

module arm64_subset_execute_tb;
	import ase_pkg::*;
	import ase_tb_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [31:0] instruction;
	logic        empty;
	logic        pop;
	logic [63:0] next_pc;
	logic [2:0]  status;
	logic        dest_written;
	logic [4:0]  dest_index;
	logic [63:0] dest_value;
	logic [3:0]  nzcv;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	logic [63:0] cur_base;

	arm64_subset_execute dut (.*);

	ase_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("arm64_subset_execute regression: fail");
			$finish;
		end
	end

	// instruction encoders
	function automatic logic [31:0] enc_r(input logic [10:0] op, input logic [4:0] rd,
			input logic [4:0] rn, input logic [4:0] rm, input logic [5:0] sh);
		return {op, rm, sh, rn, rd};
	endfunction

	function automatic logic [31:0] enc_i(input logic [8:0] op, input logic lsl12,
			input logic [11:0] imm, input logic [4:0] rn, input logic [4:0] rd);
		return {op, lsl12, imm, rn, rd};
	endfunction

	function automatic logic [31:0] enc_ubfm(input logic [5:0] immr, input logic [5:0] imms,
			input logic [4:0] rn, input logic [4:0] rd);
		return {UBFM_OP, immr, imms, rn, rd};
	endfunction

	function automatic logic [31:0] enc_lsl(input logic [4:0] rd, input logic [4:0] rn,
			input logic [5:0] s);
		return enc_ubfm(6'd0 - s, 6'd63 - s, rn, rd);
	endfunction

	function automatic logic [31:0] enc_mem(input logic [10:0] op, input logic [8:0] simm,
			input logic [4:0] rn, input logic [4:0] rt);
		return {op, simm, 2'b00, rn, rt};
	endfunction

	function automatic logic [31:0] enc_wide(input logic [10:0] op, input logic [15:0] imm,
			input logic [4:0] rd);
		return {op, imm, rd};
	endfunction

	function automatic logic [31:0] enc_cb(input logic [7:0] op, input logic [18:0] off,
			input logic [4:0] rt);
		return {op, off, rt};
	endfunction

	function automatic logic [4:0] pick_dest();
		// x20..x23 hold data pointers for the current phase
		return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
			: 5'($urandom_range(0, 19));
	endfunction

	function automatic logic [31:0] random_instr();
		logic [4:0]  rd, rn, rm;
		logic [10:0] op;
		logic [8:0]  iop;
		rd = pick_dest();
		rn = 5'($urandom_range(0, 31));
		rm = 5'($urandom_range(0, 31));
		case ($urandom_range(0, 15))
			0: begin
				case ($urandom_range(0, 5))
					0: op = OPC_ADD;
					1: op = OPC_ADDS;
					2: op = OPC_SUBS;
					3: op = OPC_ANDS;
					4: op = OPC_EOR;
					default: op = OPC_ORR;
				endcase
				return enc_r(op, rd, rn, rm, 6'($urandom_range(0, 63)));
			end
			1: return enc_r(OPC_ADCS, rd, rn, rm, 6'd0);
			2: return enc_r(OPC_MUL, rd, rn, rm, MUL_RA);
			3: begin
				case ($urandom_range(0, 2))
					0: iop = IMM_ADD;
					1: iop = IMM_ADDS;
					default: iop = IMM_SUBS;
				endcase
				return enc_i(iop, 1'($urandom), 12'($urandom), rn, rd);
			end
			4: return enc_wide(OPC_MOVZ, 16'($urandom), rd);
			5: return enc_lsl(rd, rn, 6'($urandom_range(1, 63)));
			6: return enc_ubfm(6'($urandom), 6'd63, rn, rd);
			7, 8, 9, 10: begin
				case ($urandom_range(0, 5))
					0: op = OPC_LDUR;
					1: op = OPC_LDURB;
					2: op = OPC_LDURH;
					3: op = OPC_STUR;
					4: op = OPC_STURB;
					default: op = OPC_STURH;
				endcase
				if ($urandom_range(0, 9) != 0) rn = 5'($urandom_range(20, 23));
				return enc_mem(op, 9'($urandom), rn, op[1] ? rd : rm);
			end
			11: return {BCOND_OP, 19'($urandom), 1'b0, 4'($urandom)};
			12: return enc_cb($urandom_range(0, 1) ? CBZ_OP : CBNZ_OP, 19'($urandom), rm);
			13: return $urandom_range(0, 1) ? {B_OP, 26'($urandom)} : (BR_WORD | {rn, 5'd0});
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input logic [31:0] ins);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		instruction <= ins;
		do @(posedge clk); while (full);
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [63:0] sp, input logic [63:0] db);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_PC;
		cfg_data  <= sp;
		@(posedge clk);
		cfg_index <= REG_DATA_BASE;
		cfg_data  <= db;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_base  = db;
	endtask

	task automatic load_const(input logic [4:0] r, input logic [63:0] v);
		send(enc_wide(OPC_MOVZ, v[63:48], r));
		for (int k = 2; k >= 0; k--) begin
			send(enc_lsl(r, r, 6'd16));
			send(enc_i(IMM_ADD, 1'b1, {8'd0, v[16 * k + 12 +: 4]}, r, r));
			send(enc_i(IMM_ADD, 1'b0, v[16 * k +: 12], r, r));
		end
	endtask

	// result side: random stalls with occasional stretches of back-to-back pops
	initial begin
		int gap;
		int left;
		bit steady;
		left = 0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if (left == 0) begin
				left   = $urandom_range(10, 60);
				steady = $urandom_range(0, 2) == 0;
			end
			left--;
			gap = steady ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		logic [63:0] sp_list [6];
		logic [63:0] db_list [6];
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		instruction = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_START_PC;
		cfg_data    = '0;
		idle_cycles = 0;
		cur_base    = RESET_BASE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: flag extremes, most operations, faults, unknown encodings
		send(enc_i(IMM_SUBS, 1'b0, 12'd1, 5'd31, 5'd2));
		send(enc_r(OPC_ADDS, 5'd3, 5'd2, 5'd2, 6'd0));
		send(enc_r(OPC_ADCS, 5'd4, 5'd2, 5'd31, 6'd0));
		send(enc_wide(OPC_MOVZ, 16'hFFFF, 5'd1));
		send(enc_lsl(5'd1, 5'd1, 6'd63));
		send(enc_r(OPC_SUBS, 5'd5, 5'd1, 5'd2, 6'd63));
		send(enc_r(OPC_ANDS, 5'd6, 5'd2, 5'd1, 6'd0));
		send(enc_r(OPC_EOR, 5'd7, 5'd1, 5'd2, 6'd1));
		send(enc_r(OPC_ORR, 5'd8, 5'd31, 5'd2, 6'd32));
		send(enc_r(OPC_MUL, 5'd9, 5'd2, 5'd2, MUL_RA));
		send(enc_ubfm(6'd63, 6'd63, 5'd2, 5'd10));
		send(enc_i(IMM_ADDS, 1'b1, 12'hFFF, 5'd2, 5'd31));
		send(enc_i(IMM_ADD, 1'b1, 12'h100, 5'd31, 5'd20));
		send(enc_lsl(5'd20, 5'd20, 6'd16));
		send(enc_mem(OPC_STUR, 9'd0, 5'd20, 5'd2));
		send(enc_mem(OPC_LDURH, 9'd1, 5'd20, 5'd11));
		send(enc_mem(OPC_STURB, 9'h0FF, 5'd20, 5'd1));
		send(enc_mem(OPC_LDUR, 9'h0FF, 5'd20, 5'd12));
		send(enc_mem(OPC_LDURB, 9'h1FF, 5'd20, 5'd13));
		send(enc_mem(OPC_STUR, 9'd0, 5'd31, 5'd2));
		for (int c = 0; c < 16; c++) send({BCOND_OP, 19'h7FFFF, 1'b0, 4'(c)});
		send({BCOND_OP, 19'h3FFFF, 1'b1, COND_EQ});
		send(enc_cb(CBZ_OP, 19'h40000, 5'd31));
		send(enc_cb(CBNZ_OP, 19'h1, 5'd2));
		send(BR_WORD | {5'd2, 5'd0});
		send({B_OP, 26'h2000000});
		send(enc_wide({OPC_MOVZ[10:2], 2'b01}, 16'h1234, 5'd3));
		send(enc_r(OPC_MUL, 5'd3, 5'd2, 5'd2, 6'd0));
		send(enc_r(OPC_ADCS, 5'd3, 5'd2, 5'd2, 6'd1));
		send({OPC_LDUR, 9'd8, 2'b01, 5'd20, 5'd3});
		send(enc_ubfm(6'd5, 6'd10, 5'd2, 5'd3));
		send(enc_wide(OPC_HLT, 16'd0, 5'd1));

		sp_list = '{64'd0, '1, {$urandom, $urandom}, RESET_PC, {$urandom, $urandom}, 64'd4};
		db_list = '{64'd0, 64'hFFFF_FFFF_FFFF_F000, '1, {$urandom, $urandom}, RESET_BASE,
			{$urandom, $urandom}};
		for (int p = 0; p < 6; p++) begin
			drain();
			configure(sp_list[p], db_list[p]);
			for (int r = 20; r < 24; r++)
				load_const(5'(r), cur_base + 64'($urandom_range(256, DMEM_BYTES - 257)));
			repeat (280) send(random_instr());
		end

		// halt, then a few transactions that must be ignored
		send(enc_wide(OPC_HLT, 16'($urandom), 5'd0));
		repeat (4) send(random_instr());
		drain();
		if (fail_count == 0 && pending == 0)
			$display("arm64_subset_execute regression: pass");
		else
			$display("arm64_subset_execute regression: fail");
		$finish;
	end

endmodule
